>>> hdl/assert_macros.svh
// Assertion shorthands for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/wfts_pkg.sv
package wfts_pkg;

   localparam int REQ_BITS   = 19;
   localparam int REQ_TDATA  = 24;
   localparam int RSP_BITS   = 20;
   localparam int RSP_TDATA  = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [3:0] DIR_STOP    = 4'd0;
   localparam logic [3:0] DIR_FORWARD = 4'd9;
   localparam logic [3:0] DIR_ROTATE  = 4'd10;
   localparam logic [6:0] FULL_DUTY   = 7'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_LIMIT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_PERCENT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_PULSES   = 3'd4;

   localparam logic [7:0] RST_NEAR_LIMIT    = 8'd7;
   localparam logic [7:0] RST_CLOSE_LIMIT   = 8'd6;
   localparam logic [7:0] RST_FAR_LIMIT     = 8'd30;
   localparam logic [6:0] RST_STEER_PERCENT = 7'd70;
   localparam logic [7:0] RST_TURN_PULSES   = 8'd92; // first count past 180 degrees

   // packed with the first field in the highest bits
   typedef struct packed {
      logic       front_hit;
      logic       right_pulse;
      logic       left_pulse;
      logic [7:0] dist_right;
      logic [7:0] dist_left;
   } req_type;

   typedef struct packed {
      logic       turn_done;
      logic       rotating;
      logic [6:0] duty_right;
      logic [6:0] duty_left;
      logic [3:0] motor_dir;
   } rsp_type;

   typedef struct packed {
      logic [7:0] near_limit;
      logic [7:0] close_limit;
      logic [7:0] far_limit;
      logic [6:0] steer_percent;
      logic [7:0] turn_pulses;
   } cfg_type;

endpackage

>>> hdl/wfts_step.sv
module wfts_step (
   input  wfts_pkg::req_type item,
   input  wfts_pkg::cfg_type cfg,
   input  logic              mode_rotate,
   input  logic [7:0]        pulse_count,
   output wfts_pkg::rsp_type result,
   output logic              mode_rotate_next,
   output logic [7:0]        pulse_count_next
);
   import wfts_pkg::*;

   logic [6:0] steer;
   logic       steer_left;
   logic       steer_right;
   logic [8:0] sum;
   logic [7:0] count_sat;

   assign steer = (cfg.steer_percent > FULL_DUTY) ? FULL_DUTY : cfg.steer_percent;

   assign steer_left  = ((item.dist_left >= cfg.near_limit) ||
                         (item.dist_right <= cfg.close_limit)) &&
                        (item.dist_left < cfg.far_limit);
   assign steer_right = ((item.dist_right >= cfg.near_limit) ||
                         (item.dist_left <= cfg.close_limit)) &&
                        (item.dist_right < cfg.far_limit);

   assign sum = {1'b0, pulse_count} + {8'd0, item.left_pulse} + {8'd0, item.right_pulse};
   assign count_sat = sum[8] ? 8'hFF : sum[7:0];

   always_comb begin
      result.motor_dir  = DIR_FORWARD;
      result.duty_left  = FULL_DUTY;
      result.duty_right = FULL_DUTY;
      result.rotating   = 1'b0;
      result.turn_done  = 1'b0;
      mode_rotate_next  = mode_rotate;
      pulse_count_next  = pulse_count;
      priority if (!mode_rotate && item.front_hit) begin
         result.motor_dir = DIR_STOP;
         result.rotating  = 1'b1;
         mode_rotate_next = 1'b1;
         pulse_count_next = 8'd0;
      end else if (!mode_rotate) begin
         if (steer_left) begin
            result.duty_left = steer;
         end else if (steer_right) begin
            result.duty_right = steer;
         end
      end else if (count_sat >= cfg.turn_pulses) begin
         result.motor_dir = DIR_STOP;
         result.turn_done = 1'b1;
         mode_rotate_next = 1'b0;
         pulse_count_next = 8'd0;
      end else begin
         result.motor_dir = DIR_ROTATE;
         result.rotating  = 1'b1;
         pulse_count_next = count_sat;
      end
   end

endmodule

>>> hdl/wall_follow_turn_sequencer.sv
// Wall-follow and turn sequencer: one tick transaction in, one motor command out.
// Each tick is latched in an input register, evaluated against the mode and
// pulse count in one pass of compare logic, and written to an output register,
// so a tick is accepted every cycle while rsp_tready stays high. Forward mode
// steers with the near, close and far limits; a front hit stops and starts a
// right spin that ends once the summed encoder pulses reach turn_pulses. Write
// the csr_ registers only while no tick is in flight.
module wall_follow_turn_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   // dist_left[7:0], dist_right[15:8], left_pulse[16], right_pulse[17],
   // front_hit[18], zero fill up to 23
   input  logic [wfts_pkg::REQ_TDATA-1:0]    req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // motor_dir[3:0], duty_left[10:4], duty_right[17:11], rotating[18],
   // turn_done[19], zero fill up to 23
   output logic [wfts_pkg::RSP_TDATA-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wfts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wfts_pkg::CSR_DATA_W-1:0]   csr_data
);
   import wfts_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    mode_ff, mode_in;
   logic [7:0] count_ff, count_in;
   cfg_type cfg_ff, cfg_in;

   rsp_type step_result;
   logic    step_mode;
   logic [7:0] step_count;
   logic    advance;
   logic    take;

   wfts_step u_step (
      .item             (in_data_ff),
      .cfg              (cfg_ff),
      .mode_rotate      (mode_ff),
      .pulse_count      (count_ff),
      .result           (step_result),
      .mode_rotate_next (step_mode),
      .pulse_count_next (step_count)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA-RSP_BITS){1'b0}}, out_data_ff};

   always_comb begin
      in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : ((rsp_tready) ? 1'b0 : out_valid_ff);
      mode_in      = advance ? step_mode : mode_ff;
      count_in     = advance ? step_count : count_ff;
      cfg_in       = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NEAR_LIMIT:    cfg_in.near_limit    = csr_data;
            CSR_CLOSE_LIMIT:   cfg_in.close_limit   = csr_data;
            CSR_FAR_LIMIT:     cfg_in.far_limit     = csr_data;
            CSR_STEER_PERCENT: cfg_in.steer_percent = csr_data[6:0];
            CSR_TURN_PULSES:   cfg_in.turn_pulses   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         count_ff     <= 8'd0;
         cfg_ff       <= '{near_limit:    RST_NEAR_LIMIT,
                           close_limit:   RST_CLOSE_LIMIT,
                           far_limit:     RST_FAR_LIMIT,
                           steer_percent: RST_STEER_PERCENT,
                           turn_pulses:   RST_TURN_PULSES};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_type'(req_tdata[REQ_BITS-1:0]);
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

endmodule

>>> hdl/wfts_checker.sv
`include "assert_macros.svh"

module wfts_checker (
   input logic                           clock,
   input logic                           reset,
   input logic [wfts_pkg::RSP_TDATA-1:0] rsp_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);
   import wfts_pkg::*;

   rsp_type rsp;
   logic    stall;
   logic    done_beat;
   logic    fwd_beat;
   logic    stop_idle;
   logic    spin_flags;
   logic    duty_ok;

   assign rsp        = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
   assign stall      = rsp_tvalid && !rsp_tready;
   assign done_beat  = rsp_tvalid && rsp.turn_done;
   assign fwd_beat   = rsp_tvalid && (rsp.motor_dir == DIR_FORWARD);
   assign stop_idle  = (rsp.motor_dir == DIR_STOP) && !rsp.rotating;
   assign spin_flags = rsp.rotating || rsp.turn_done;
   assign duty_ok    = (rsp.duty_left <= FULL_DUTY) && (rsp.duty_right <= FULL_DUTY);

   `ASSERT_RUN(a_hold, clock, reset, stall |=> rsp_tvalid && $stable(rsp_tdata), "stall broken")
   `ASSERT_RUN(a_done_stop, clock, reset, done_beat |-> stop_idle, "turn end not a stop")
   `ASSERT_RUN(a_fwd_mode, clock, reset, fwd_beat |-> !spin_flags, "forward flags rotation")
   `ASSERT_RUN(a_duty_range, clock, reset, rsp_tvalid |-> duty_ok, "duty above full")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid, "result valid after reset")

endmodule

bind wall_follow_turn_sequencer wfts_checker u_wfts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

>>> verif/tb_wall_follow_turn_sequencer.sv
module tb_wall_follow_turn_sequencer;
   timeunit 1ns;
   timeprecision 1ps;
   import wfts_pkg::*;

   localparam int ITEMS_PER_PHASE = 300;
   localparam int NUM_PHASES      = 6;
   localparam int DRAIN_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef enum logic [1:0] {ROW_TICK, ROW_TICK_KNOWN, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      req_type               tick;
      rsp_type               cmd;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic [REQ_TDATA-1:0]  req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_TDATA-1:0]  rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // shadow of the sequencer: registers, mode and pulse count
   cfg_type               cfg_now;
   logic                  spin_mode;
   logic [7:0]            pulse_tally;

   rsp_type               cmd_queue[$];
   plan_row_type          plan[$];
   cfg_type               phase_cfg[NUM_PHASES];
   logic                  pin_valid;
   rsp_type               pin_cmd;
   logic                  no_idle;
   int                    err_count   = 0;
   int                    idle_cycles = 0;

   wall_follow_turn_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type motor_cmd(logic [3:0] dir, logic [6:0] dl, logic [6:0] dr,
                                         logic rot, logic done);
      rsp_type c;
      c.motor_dir  = dir;
      c.duty_left  = dl;
      c.duty_right = dr;
      c.rotating   = rot;
      c.turn_done  = done;
      return c;
   endfunction

   function automatic req_type sensor_tick(logic [7:0] l, logic [7:0] r, logic lp, logic rp,
                                           logic hit);
      req_type t;
      t.dist_left   = l;
      t.dist_right  = r;
      t.left_pulse  = lp;
      t.right_pulse = rp;
      t.front_hit   = hit;
      return t;
   endfunction

   function automatic plan_row_type tick_row(req_type t);
      plan_row_type row;
      row.kind = ROW_TICK;
      row.tick = t;
      row.cmd  = '0;
      row.idx  = '0;
      row.val  = '0;
      return row;
   endfunction

   function automatic plan_row_type known_row(req_type t, rsp_type c);
      plan_row_type row;
      row      = tick_row(t);
      row.kind = ROW_TICK_KNOWN;
      row.cmd  = c;
      return row;
   endfunction

   function automatic plan_row_type reg_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row      = tick_row('0);
      row.kind = ROW_REG;
      row.idx  = idx;
      row.val  = val;
      return row;
   endfunction

   // one tick through the shadow sequencer; updates mode and count
   function automatic rsp_type next_command(req_type t);
      rsp_type    c;
      logic [6:0] steer;
      logic [8:0] sum;
      c = motor_cmd(DIR_FORWARD, FULL_DUTY, FULL_DUTY, 1'b0, 1'b0);
      if (!spin_mode) begin
         if (t.front_hit) begin
            pulse_tally = '0;
            spin_mode   = 1'b1;
            c.motor_dir = DIR_STOP;
            c.rotating  = 1'b1;
         end else begin
            steer = (cfg_now.steer_percent > FULL_DUTY) ? FULL_DUTY : cfg_now.steer_percent;
            if ((t.dist_left >= cfg_now.near_limit || t.dist_right <= cfg_now.close_limit) &&
                t.dist_left < cfg_now.far_limit)
               c.duty_left = steer;
            else if ((t.dist_right >= cfg_now.near_limit ||
                      t.dist_left <= cfg_now.close_limit) &&
                     t.dist_right < cfg_now.far_limit)
               c.duty_right = steer;
         end
      end else begin
         sum = {1'b0, pulse_tally} + t.left_pulse + t.right_pulse;
         pulse_tally = (sum > 9'd255) ? 8'd255 : sum[7:0];
         if (pulse_tally >= cfg_now.turn_pulses) begin
            spin_mode   = 1'b0;
            pulse_tally = '0;
            c.motor_dir = DIR_STOP;
            c.turn_done = 1'b1;
         end else begin
            c.motor_dir = DIR_ROTATE;
            c.rotating  = 1'b1;
         end
      end
      return c;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   function automatic logic [7:0] rnd8(int lo, int hi);
      int v;
      v = $urandom_range(hi, lo);
      return v[7:0];
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // distances cluster around the current thresholds so every compare flips
   function automatic logic [7:0] pick_dist();
      logic [7:0] base;
      case ($urandom_range(0, 3))
         0: return rnd8(0, 255);
         1: base = cfg_now.near_limit;
         2: base = cfg_now.close_limit;
         default: base = cfg_now.far_limit;
      endcase
      base = base + rnd8(0, 2) - 8'd1;
      return base;
   endfunction

   function automatic req_type random_tick();
      req_type t;
      t.dist_left   = pick_dist();
      t.dist_right  = pick_dist();
      t.left_pulse  = 1'($urandom_range(0, 1));
      t.right_pulse = 1'($urandom_range(0, 1));
      t.front_hit   = ($urandom_range(0, spin_mode ? 3 : 11) == 0);
      return t;
   endfunction

   task automatic send_tick(input req_type t, input logic pinned, input rsp_type c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA-REQ_BITS){1'b0}}, t};
      pin_valid  <= pinned;
      pin_cmd    <= c;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off the sender until every outstanding command has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cmd_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      rsp_type seen;
      if (reset) begin
         cfg_now = '{near_limit: RST_NEAR_LIMIT, close_limit: RST_CLOSE_LIMIT,
                     far_limit: RST_FAR_LIMIT, steer_percent: RST_STEER_PERCENT,
                     turn_pulses: RST_TURN_PULSES};
         spin_mode   = 1'b0;
         pulse_tally = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NEAR_LIMIT:    cfg_now.near_limit    = csr_data;
               CSR_CLOSE_LIMIT:   cfg_now.close_limit   = csr_data;
               CSR_FAR_LIMIT:     cfg_now.far_limit     = csr_data;
               CSR_STEER_PERCENT: cfg_now.steer_percent = csr_data[6:0];
               CSR_TURN_PULSES:   cfg_now.turn_pulses   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = next_command(req_tdata[REQ_BITS-1:0]);
            if (pin_valid)
               want = pin_cmd;
            cmd_queue.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[RSP_BITS-1:0];
            if (cmd_queue.size() == 0) begin
               $error("command transaction with no tick pending: motor_dir %0d",
                      seen.motor_dir);
               err_count++;
            end else begin
               want = cmd_queue.pop_front();
               check_field("motor_dir", 8'(want.motor_dir), 8'(seen.motor_dir));
               check_field("duty_left", 8'(want.duty_left), 8'(seen.duty_left));
               check_field("duty_right", 8'(want.duty_right), 8'(seen.duty_right));
               check_field("rotating", 8'(want.rotating), 8'(seen.rotating));
               check_field("turn_done", 8'(want.turn_done), 8'(seen.turn_done));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: random back-pressure
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      req_type t;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      pin_valid  = 1'b0;
      pin_cmd    = '0;
      no_idle    = 1'b0;

      // reset settings first, then rotation end, zero turn count, steer saturation and limit extremes
      plan.push_back(known_row(sensor_tick(8'd0, 8'd0, 1'b0, 1'b0, 1'b0),
                               motor_cmd(DIR_FORWARD, 7'd70, FULL_DUTY, 1'b0, 1'b0)));
      plan.push_back(known_row(sensor_tick(8'd255, 8'd255, 1'b0, 1'b0, 1'b0),
                               motor_cmd(DIR_FORWARD, FULL_DUTY, FULL_DUTY, 1'b0, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd10, 8'd255, 1'b1, 1'b0, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd255, 8'd10, 1'b0, 1'b1, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd5, 8'd20, 1'b0, 1'b0, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd30, 8'd3, 1'b0, 1'b0, 1'b0)));
      plan.push_back(known_row(sensor_tick(8'd255, 8'd255, 1'b1, 1'b1, 1'b1),
                               motor_cmd(DIR_STOP, FULL_DUTY, FULL_DUTY, 1'b1, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd0, 8'd0, 1'b1, 1'b1, 1'b1)));
      plan.push_back(tick_row(sensor_tick(8'd0, 8'd0, 1'b0, 1'b1, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd128, 8'd127, 1'b0, 1'b0, 1'b0)));
      plan.push_back(reg_row(CSR_TURN_PULSES, 8'd4));
      plan.push_back(tick_row(sensor_tick(8'd0, 8'd0, 1'b1, 1'b0, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd85, 8'd170, 1'b1, 1'b1, 1'b0)));
      plan.push_back(reg_row(CSR_TURN_PULSES, 8'd0));
      plan.push_back(known_row(sensor_tick(8'd0, 8'd0, 1'b0, 1'b0, 1'b1),
                               motor_cmd(DIR_STOP, FULL_DUTY, FULL_DUTY, 1'b1, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd0, 8'd0, 1'b0, 1'b0, 1'b0)));
      plan.push_back(reg_row(CSR_STEER_PERCENT, 8'd127));
      plan.push_back(tick_row(sensor_tick(8'd10, 8'd255, 1'b0, 1'b0, 1'b0)));
      plan.push_back(reg_row(CSR_STEER_PERCENT, 8'd0));
      plan.push_back(tick_row(sensor_tick(8'd10, 8'd255, 1'b0, 1'b0, 1'b0)));
      plan.push_back(reg_row(CSR_NEAR_LIMIT, 8'd255));
      plan.push_back(reg_row(CSR_CLOSE_LIMIT, 8'd0));
      plan.push_back(reg_row(CSR_FAR_LIMIT, 8'd255));
      plan.push_back(tick_row(sensor_tick(8'd255, 8'd0, 1'b0, 1'b0, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd0, 8'd255, 1'b0, 1'b0, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd254, 8'd0, 1'b0, 1'b0, 1'b0)));
      plan.push_back(reg_row(CSR_NEAR_LIMIT, 8'd0));
      plan.push_back(reg_row(CSR_CLOSE_LIMIT, 8'd255));
      plan.push_back(reg_row(CSR_FAR_LIMIT, 8'd0));
      plan.push_back(tick_row(sensor_tick(8'd0, 8'd0, 1'b0, 1'b0, 1'b0)));
      plan.push_back(tick_row(sensor_tick(8'd255, 8'd255, 1'b0, 1'b0, 1'b0)));

      phase_cfg[0] = '{near_limit: RST_NEAR_LIMIT, close_limit: RST_CLOSE_LIMIT,
                       far_limit: RST_FAR_LIMIT, steer_percent: RST_STEER_PERCENT,
                       turn_pulses: RST_TURN_PULSES};
      phase_cfg[1] = '{near_limit: rnd8(0, 60), close_limit: rnd8(0, 60),
                       far_limit: rnd8(0, 60), steer_percent: 7'(rnd8(0, 100)),
                       turn_pulses: rnd8(1, 24)};
      phase_cfg[2] = '{near_limit: 8'd255, close_limit: 8'd255, far_limit: 8'd255,
                       steer_percent: 7'd127, turn_pulses: 8'd255};
      phase_cfg[3] = '{near_limit: 8'd0, close_limit: 8'd0, far_limit: 8'd0,
                       steer_percent: 7'd0, turn_pulses: 8'd0};
      phase_cfg[4] = '{near_limit: rnd8(0, 255), close_limit: rnd8(0, 255),
                       far_limit: rnd8(0, 255), steer_percent: 7'(rnd8(0, 127)),
                       turn_pulses: rnd8(0, 255)};
      phase_cfg[5] = '{near_limit: rnd8(20, 40), close_limit: rnd8(0, 20),
                       far_limit: rnd8(30, 80), steer_percent: 7'(rnd8(0, 100)),
                       turn_pulses: rnd8(1, 8)};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_REG: begin
               settle();
               write_reg(plan[i].idx, plan[i].val);
            end
            ROW_TICK_KNOWN: send_tick(plan[i].tick, 1'b1, plan[i].cmd);
            default: send_tick(plan[i].tick, 1'b0, '0);
         endcase
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_reg(CSR_NEAR_LIMIT, phase_cfg[p].near_limit);
         write_reg(CSR_CLOSE_LIMIT, phase_cfg[p].close_limit);
         write_reg(CSR_FAR_LIMIT, phase_cfg[p].far_limit);
         write_reg(CSR_STEER_PERCENT, {1'b0, phase_cfg[p].steer_percent});
         write_reg(CSR_TURN_PULSES, phase_cfg[p].turn_pulses);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // back-to-back stretch at the start of each phase
            no_idle = (i < 40);
            if ((p == 0 && i == ITEMS_PER_PHASE / 2) || $urandom_range(0, 249) == 0)
               settle();
            t = random_tick();
            send_tick(t, 1'b0, '0);
         end
      end
      no_idle = 1'b0;
      settle();

      if (err_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
